// File: hdl/ehc_pkg.sv
`default_nettype none
package ehc_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned LenBits    = OffsetBits + 1;

  localparam logic [15:0] EtherArp = 16'h0806;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [7:0]  ChrCr     = 8'h0d;
  localparam logic [7:0]  ChrLf     = 8'h0a;

  localparam logic [3:0] ClsArp      = 4'd0;
  localparam logic [3:0] ClsTcp      = 4'd1;
  localparam logic [3:0] ClsUdp      = 4'd2;
  localparam logic [3:0] ClsIcmp     = 4'd3;
  localparam logic [3:0] ClsProtoNil = 4'd4;
  localparam logic [3:0] ClsUnknown  = 4'd5;
  localparam logic [3:0] ClsBadIpHl  = 4'd6;
  localparam logic [3:0] ClsBadTcpHl = 4'd7;
  localparam logic [3:0] ClsTrunc    = 4'd8;

  localparam logic [1:0] AppNone = 2'd0;
  localparam logic [1:0] AppHttp = 2'd1;
  localparam logic [1:0] AppTls  = 2'd2;
  localparam logic [1:0] AppDns  = 2'd3;

  localparam logic [2:0] IcmpEchoReply   = 3'd0;
  localparam logic [2:0] IcmpHostUnreach = 3'd1;
  localparam logic [2:0] IcmpPortUnreach = 3'd2;
  localparam logic [2:0] IcmpEchoReq     = 3'd3;
  localparam logic [2:0] IcmpOther       = 3'd4;

  localparam logic [1:0] RegHttpPort = 2'd0;
  localparam logic [1:0] RegTlsPort  = 2'd1;
  localparam logic [1:0] RegDnsPort  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  frame_class;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] payload_size;
    logic [1:0]  app_kind;
    logic [2:0]  app_code;
    logic [15:0] app_value;
    logic [1:0]  tls_version;
    logic [2:0]  icmp_kind;
    logic [15:0] icmp_type_code;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] http_port;
    logic [15:0] tls_port;
    logic [15:0] dns_port;
  } cfg_t;

  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic [15:0] ether_kind;
    logic [5:0]  ip_hdr;
    logic [15:0] ip_total;
    logic [7:0]  ip_proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] port0;
    logic [15:0] port1;
    logic [6:0]  tp_hdr;
    logic [15:0] seen;
    logic [1:0]  crlf;
    logic [15:0] app0;
    logic [15:0] app1;
    logic [7:0]  app2;
    logic        http_found;
    logic [15:0] app3;
    logic [15:0] icmp0;
    logic [15:0] icmp1;
    logic [15:0] icmp2;
  } frame_t;

  typedef struct packed {
    frame_t             fr;
    logic [LenBits-1:0] len;
  } snap_t;

  function automatic logic [15:0] payload_len(input logic [15:0] total,
                                               input logic [5:0] ip_hdr,
                                               input logic [6:0] tp_hdr);
    logic [7:0] hdr;
    hdr = {2'b00, ip_hdr} + {1'b0, tp_hdr};
    payload_len = (total > {8'h00, hdr}) ? (total - {8'h00, hdr}) : 16'h0000;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ehc_cfg.sv
`default_nettype none
module ehc_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ehc_pkg::cfg_t     cfg_o
);

  ehc_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        ehc_pkg::RegHttpPort: cfg_d.http_port = pwdata[15:0];
        ehc_pkg::RegTlsPort:  cfg_d.tls_port  = pwdata[15:0];
        ehc_pkg::RegDnsPort:  cfg_d.dns_port  = pwdata[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ehc_pkg::RegHttpPort: prdata = {16'h0000, cfg_q.http_port};
      ehc_pkg::RegTlsPort:  prdata = {16'h0000, cfg_q.tls_port};
      ehc_pkg::RegDnsPort:  prdata = {16'h0000, cfg_q.dns_port};
      default: prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.http_port <= 16'd80;
      cfg_q.tls_port  <= 16'd443;
      cfg_q.dns_port  <= 16'd53;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ehc_parse.sv
`default_nettype none
module ehc_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              in_valid_i,
  input  wire ehc_pkg::in_beat_t in_data_i,
  output logic                   snap_valid_o,
  output ehc_pkg::snap_t         snap_o
);

  logic              in_valid_q;
  ehc_pkg::in_beat_t in_q;
  ehc_pkg::frame_t   fr_q, fr_d, nx;
  logic              snap_valid_q;
  ehc_pkg::snap_t    snap_q;

  logic [ehc_pkg::OffsetBits-1:0] o;
  logic [7:0]  b;
  logic [6:0]  t;
  logic [ehc_pkg::OffsetBits-1:0] r;
  logic [15:0] plen;
  logic [7:0]  want;

  // Header capture for the byte in the input register, one byte per cycle while the pipeline is not stalled.
  always_comb begin
    nx   = fr_q;
    o    = fr_q.offset;
    b    = in_q.data_byte;
    t    = 7'd14 + {1'b0, fr_q.ip_hdr};
    r    = '0;
    plen = 16'h0000;
    want = ehc_pkg::ChrCr;
    if (o == 'd12) begin
      nx.ether_kind = {b, 8'h00};
    end else if (o == 'd13) begin
      nx.ether_kind = fr_q.ether_kind | {8'h00, b};
    end else if (fr_q.ether_kind == ehc_pkg::EtherArp) begin
      if (o >= 'd28 && o <= 'd31) nx.src_addr = {fr_q.src_addr[23:0], b};
      if (o >= 'd38 && o <= 'd41) nx.dst_addr = {fr_q.dst_addr[23:0], b};
    end else begin
      if (o == 'd14) begin
        nx.ip_hdr = {b[3:0], 2'b00};
      end else if (o == 'd16) begin
        nx.ip_total = {b, 8'h00};
      end else if (o == 'd17) begin
        nx.ip_total = fr_q.ip_total | {8'h00, b};
      end else if (o == 'd23) begin
        nx.ip_proto = b;
        if (b == ehc_pkg::ProtoUdp) nx.tp_hdr = 7'd8;
      end else if (o >= 'd26 && o <= 'd29) begin
        nx.src_addr = {fr_q.src_addr[23:0], b};
      end else if (o >= 'd30 && o <= 'd33) begin
        nx.dst_addr = {fr_q.dst_addr[23:0], b};
      end
      t = 7'd14 + {1'b0, nx.ip_hdr};
      if (nx.ip_hdr >= 6'd20 && o >= {{(ehc_pkg::OffsetBits-7){1'b0}}, t}) begin
        r = o - {{(ehc_pkg::OffsetBits-7){1'b0}}, t};
        if (nx.ip_proto == ehc_pkg::ProtoTcp || nx.ip_proto == ehc_pkg::ProtoUdp) begin
          if (r < 'd2) nx.port0 = {fr_q.port0[7:0], b};
          else if (r < 'd4) nx.port1 = {fr_q.port1[7:0], b};
          if (nx.ip_proto == ehc_pkg::ProtoTcp && r == 'd12) nx.tp_hdr = {1'b0, b[7:4], 2'b00};
          plen = ehc_pkg::payload_len(nx.ip_total, nx.ip_hdr, nx.tp_hdr);
          if ((nx.ip_proto == ehc_pkg::ProtoUdp || nx.tp_hdr >= 7'd20) &&
              r >= {{(ehc_pkg::OffsetBits-7){1'b0}}, nx.tp_hdr} && fr_q.seen < plen) begin
            case (fr_q.seen)
              16'd0: nx.app0[15:8] = b;
              16'd1: nx.app0[7:0]  = b;
              16'd2: nx.app1[15:8] = b;
              16'd3: nx.app1[7:0]  = b;
              16'd5: nx.app2       = b;
              default: nx.app2     = fr_q.app2;
            endcase
            if (!fr_q.http_found) begin
              want = fr_q.crlf[0] ? ehc_pkg::ChrLf : ehc_pkg::ChrCr;
              if (b == want) begin
                if (fr_q.crlf == 2'd3) begin
                  nx.http_found = 1'b1;
                  nx.app3       = fr_q.seen - 16'd3;
                  nx.crlf       = 2'd0;
                end else begin
                  nx.crlf = fr_q.crlf + 2'd1;
                end
              end else begin
                nx.crlf = (b == ehc_pkg::ChrCr) ? 2'd1 : 2'd0;
              end
            end
            nx.seen = fr_q.seen + 16'd1;
          end
        end else if (nx.ip_proto == ehc_pkg::ProtoIcmp) begin
          if (r == 'd0) nx.icmp0[15:8] = b;
          else if (r == 'd1) nx.icmp0[7:0] = b;
          else if (r == 'd4 || r == 'd5) nx.icmp1 = {fr_q.icmp1[7:0], b};
          else if (r == 'd6 || r == 'd7) nx.icmp2 = {fr_q.icmp2[7:0], b};
        end
      end
    end
  end

  always_comb begin
    fr_d = fr_q;
    if (en_i && in_valid_q) begin
      if (in_q.end_of_frame) begin
        fr_d = '0;
      end else begin
        fr_d = nx;
        if (o != '1) fr_d.offset = o + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      snap_valid_q <= 1'b0;
      fr_q         <= '0;
    end else begin
      fr_q <= fr_d;
      if (en_i) begin
        in_valid_q   <= in_valid_i;
        snap_valid_q <= in_valid_q && in_q.end_of_frame;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_q <= in_data_i;
      if (in_valid_q && in_q.end_of_frame) begin
        snap_q.fr  <= nx;
        snap_q.len <= {1'b0, o} + 1'b1;
      end
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule
`default_nettype wire

// File: hdl/ehc_summary.sv
`default_nettype none
module ehc_summary (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            snap_valid_i,
  input  wire ehc_pkg::snap_t  snap_i,
  input  wire ehc_pkg::cfg_t   cfg_i,
  output logic                 out_valid_o,
  output ehc_pkg::out_beat_t   out_data_o
);

  ehc_pkg::out_beat_t res, out_q;
  logic                        out_valid_q;
  ehc_pkg::frame_t             f;
  logic [ehc_pkg::LenBits-1:0] len, t;
  logic [7:0]  ty, cd, ct, v1, v2;
  logic [15:0] psize;
  logic [2:0]  code;

  always_comb begin
    res   = '0;
    f     = snap_i.fr;
    len   = snap_i.len;
    t     = ehc_pkg::LenBits'(14) + {{(ehc_pkg::LenBits-6){1'b0}}, f.ip_hdr};
    ty    = f.icmp0[15:8];
    cd    = f.icmp0[7:0];
    ct    = f.app0[15:8];
    v1    = f.app0[7:0];
    v2    = f.app1[15:8];
    psize = ehc_pkg::payload_len(f.ip_total, f.ip_hdr, f.tp_hdr);
    code  = 3'd0;
    res.frame_class = ehc_pkg::ClsTrunc;
    if (f.ether_kind == ehc_pkg::EtherArp) begin
      if (len >= ehc_pkg::LenBits'(42)) begin
        res.frame_class         = ehc_pkg::ClsArp;
        res.source_address      = f.src_addr;
        res.destination_address = f.dst_addr;
      end
    end else if (len < ehc_pkg::LenBits'(15)) begin
      res.frame_class = ehc_pkg::ClsTrunc;
    end else if (f.ip_hdr < 6'd20) begin
      res.frame_class = ehc_pkg::ClsBadIpHl;
    end else if (len < ehc_pkg::LenBits'(34)) begin
      res.frame_class = ehc_pkg::ClsTrunc;
    end else if (f.ip_proto == ehc_pkg::ProtoTcp) begin
      if (len >= t + ehc_pkg::LenBits'(13)) begin
        res.source_address      = f.src_addr;
        res.destination_address = f.dst_addr;
        if (f.tp_hdr < 7'd20) begin
          res.frame_class = ehc_pkg::ClsBadTcpHl;
        end else begin
          res.frame_class      = ehc_pkg::ClsTcp;
          res.source_port      = f.port0;
          res.destination_port = f.port1;
          res.payload_size     = psize;
          if (psize != 16'h0000) begin
            if (f.port0 == cfg_i.http_port || f.port1 == cfg_i.http_port) begin
              res.app_kind = ehc_pkg::AppHttp;
              if (f.http_found) begin
                res.app_code  = 3'd1;
                res.app_value = f.app3;
              end
            end else if (f.port0 == cfg_i.tls_port || f.port1 == cfg_i.tls_port) begin
              res.app_kind = ehc_pkg::AppTls;
              case (ct)
                8'h16:   code = 3'd1;
                8'h15:   code = 3'd2;
                8'h17:   code = 3'd3;
                8'h14:   code = 3'd4;
                default: code = 3'd0;
              endcase
              res.app_code = code;
              if (code == 3'd1) res.app_value = {8'h00, f.app2};
              if (code != 3'd0 && v1 == 8'h03 && v2 >= 8'd1 && v2 <= 8'd3) begin
                res.tls_version = v2[1:0];
              end
            end
          end
        end
      end
    end else if (f.ip_proto == ehc_pkg::ProtoUdp) begin
      if (len >= t + ehc_pkg::LenBits'(4)) begin
        res.frame_class         = ehc_pkg::ClsUdp;
        res.source_address      = f.src_addr;
        res.destination_address = f.dst_addr;
        res.source_port         = f.port0;
        res.destination_port    = f.port1;
        res.payload_size        = psize;
        if (psize != 16'h0000 &&
            (f.port0 == cfg_i.dns_port || f.port1 == cfg_i.dns_port)) begin
          res.app_kind  = ehc_pkg::AppDns;
          res.app_value = f.app0;
          case (f.app1)
            16'h0100: res.app_code = 3'd1;
            16'h8180: res.app_code = 3'd2;
            16'h8103: res.app_code = 3'd3;
            default:  res.app_code = 3'd0;
          endcase
        end
      end
    end else if (f.ip_proto == ehc_pkg::ProtoIcmp) begin
      if (len >= t + ehc_pkg::LenBits'(2) &&
          !(ty == 8'd8 && len < t + ehc_pkg::LenBits'(8))) begin
        res.frame_class         = ehc_pkg::ClsIcmp;
        res.source_address      = f.src_addr;
        res.destination_address = f.dst_addr;
        res.icmp_type_code      = f.icmp0;
        if (ty == 8'd0 && cd == 8'd0)      res.icmp_kind = ehc_pkg::IcmpEchoReply;
        else if (ty == 8'd3 && cd == 8'd1) res.icmp_kind = ehc_pkg::IcmpHostUnreach;
        else if (ty == 8'd3 && cd == 8'd3) res.icmp_kind = ehc_pkg::IcmpPortUnreach;
        else if (ty == 8'd8 && cd == 8'd0) res.icmp_kind = ehc_pkg::IcmpEchoReq;
        else                               res.icmp_kind = ehc_pkg::IcmpOther;
        if (ty == 8'd8) begin
          res.source_port      = f.icmp1;
          res.destination_port = f.icmp2;
        end
      end
    end else begin
      res.frame_class = (f.ip_proto == 8'd0) ? ehc_pkg::ClsProtoNil : ehc_pkg::ClsUnknown;
      res.source_address      = f.src_addr;
      res.destination_address = f.dst_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && snap_valid_i) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: hdl/ethernet_ipv4_header_classifier_unit.sv
`default_nettype none
// Ethernet/IPv4 header classifier. Frame bytes enter one beat per clock on the
// input channel while the pipeline is not stalled, starting at the destination
// MAC address, and the beat flagged end_of_frame yields exactly one summary
// beat; no other beat yields any. A new byte can be accepted in every cycle in
// which the pipeline is not stalled. The accepted byte is registered in the
// input register, the header capture logic loads the snapshot register from
// it, and the summary logic behind the snapshot loads the output register.
// Every stage moves together, and the whole pipeline holds only while a
// finished summary waits in the output register with the consumer not ready.
// The ports matched against HTTP, TLS and DNS traffic live in an APB-style
// register file at byte addresses 0, 4 and 8 and should be written only while
// the block is idle.
module ethernet_ipv4_header_classifier_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ehc_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ehc_pkg::out_beat_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  ehc_pkg::cfg_t  cfg;
  ehc_pkg::snap_t snap;
  logic           snap_valid;
  logic           en;

  // The pipeline advances unless a finished summary is stuck at the output.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  ehc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register and per-byte header capture; the frame state is handed
  // over as a snapshot on the last byte and cleared for the next frame.
  ehc_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  // Classification of the snapshot into the result register.
  ehc_summary u_summary (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// File: hdl/ehc_checker.sv
`default_nettype none
module ehc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire ehc_pkg::out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("summary beat dropped or changed while stalled");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the pipeline is stalled");

  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_class == ehc_pkg::ClsTrunc |->
      out_data_o.source_address == 32'h0 && out_data_o.app_kind == ehc_pkg::AppNone)
    else $error("truncated frame carries fields");

  a_app: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.app_kind != ehc_pkg::AppNone |->
      out_data_o.frame_class == ehc_pkg::ClsTcp || out_data_o.frame_class == ehc_pkg::ClsUdp)
    else $error("application class on a non-transport frame");

endmodule

bind ethernet_ipv4_header_classifier_unit ehc_checker u_ehc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;

  // Frame kinds and payload flavours used by the frame builder.
  localparam int KArp   = 0;
  localparam int KTcp   = 1;
  localparam int KUdp   = 2;
  localparam int KIcmp  = 3;
  localparam int KNil   = 4;
  localparam int KOther = 5;

  localparam int PlRand = 0;
  localparam int PlHttp = 1;
  localparam int PlTls  = 2;
  localparam int PlDns  = 3;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned OffsetMax  = (1 << ehc_pkg::OffsetBits) - 1;
  localparam int unsigned Drain      = 16;

  // Builder controls; -1 asks the builder to choose at random.
  typedef struct {
    int kind;
    int eth;
    int ihl;
    int doff;
    int app;
    int icmp_ty;
    int icmp_cd;
    int cut;
    int plen;
    int pad;
  } frame_spec_t;

  typedef struct {
    frame_spec_t spec;
    bit          typed;
    logic [3:0]  cls;
  } dir_row_t;

  typedef struct {
    ehc_pkg::in_beat_t  beat;
    bit                 typed;
    ehc_pkg::out_beat_t fixed;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  ehc_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ehc_pkg::out_beat_t out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ethernet_ipv4_header_classifier_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock with a period of four time units.
  initial begin
    forever #2 clk = ~clk;
  end

  // Byte stream waiting to be offered, and summaries waiting to arrive.
  byte_item_t          byte_q[$];
  ehc_pkg::out_beat_t  summary_q[$];
  byte_item_t          offered;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Predictor copy of the port registers and of the per-frame capture state.
  logic [15:0] http_port_cfg = 16'd80;
  logic [15:0] tls_port_cfg  = 16'd443;
  logic [15:0] dns_port_cfg  = 16'd53;

  int unsigned cur_offset;
  logic [15:0] eth_type;
  logic [7:0]  ip_hlen;
  logic [15:0] ip_len;
  logic [7:0]  ip_proto_r;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [7:0]  l4_hlen;
  logic [15:0] pay_taken;
  logic [1:0]  crlf_cnt;
  logic [15:0] pay01;
  logic [15:0] pay23;
  logic [15:0] pay5_found;
  logic [15:0] http_len;
  logic [15:0] icmp_tc;
  logic [15:0] icmp_id;
  logic [15:0] icmp_seq;

  function automatic void clear_frame_state();
    cur_offset = 0; eth_type = '0; ip_hlen = '0; ip_len = '0; ip_proto_r = '0;
    src_ip = '0; dst_ip = '0; sport_r = '0; dport_r = '0; l4_hlen = '0;
    pay_taken = '0; crlf_cnt = '0; pay01 = '0; pay23 = '0; pay5_found = '0;
    http_len = '0; icmp_tc = '0; icmp_id = '0; icmp_seq = '0;
  endfunction

  // IP total length less both header lengths, never below zero.
  function automatic logic [15:0] expected_payload();
    int unsigned hdr;
    hdr = ip_hlen + l4_hlen;
    return (ip_len > hdr) ? 16'(ip_len - hdr) : 16'd0;
  endfunction

  // One payload byte: keep the bytes the application checks look at and
  // run the search for the blank line that closes an HTTP header.
  function automatic void take_payload_byte(input logic [7:0] b);
    logic [15:0] idx;
    logic [7:0]  want;
    idx = pay_taken;
    if (idx == 0) pay01[15:8] = b;
    else if (idx == 1) pay01[7:0] = b;
    else if (idx == 2) pay23[15:8] = b;
    else if (idx == 3) pay23[7:0] = b;
    else if (idx == 5) pay5_found[7:0] = b;
    if (!pay5_found[8]) begin
      want = crlf_cnt[0] ? ehc_pkg::ChrLf : ehc_pkg::ChrCr;
      if (b == want) begin
        if (crlf_cnt == 2'd3) begin
          pay5_found[8] = 1'b1;
          http_len = idx - 16'd3;
          crlf_cnt = 2'd0;
        end else begin
          crlf_cnt = crlf_cnt + 2'd1;
        end
      end else begin
        crlf_cnt = (b == ehc_pkg::ChrCr) ? 2'd1 : 2'd0;
      end
    end
    pay_taken = idx + 16'd1;
  endfunction

  function automatic void capture_byte(input int unsigned o, input logic [7:0] b);
    int unsigned t;
    int unsigned r;
    if (o == 12) begin
      eth_type = {b, 8'h00};
      return;
    end
    if (o == 13) begin
      eth_type[7:0] = b;
      return;
    end
    if (eth_type == ehc_pkg::EtherArp) begin
      if (o >= 28 && o <= 31) src_ip = {src_ip[23:0], b};
      if (o >= 38 && o <= 41) dst_ip = {dst_ip[23:0], b};
      return;
    end
    if (o == 14) ip_hlen = {2'b00, b[3:0], 2'b00};
    else if (o == 16) ip_len = {b, 8'h00};
    else if (o == 17) ip_len[7:0] = b;
    else if (o == 23) begin
      ip_proto_r = b;
      if (b == ehc_pkg::ProtoUdp) l4_hlen = 8'd8;
    end
    else if (o >= 26 && o <= 29) src_ip = {src_ip[23:0], b};
    else if (o >= 30 && o <= 33) dst_ip = {dst_ip[23:0], b};
    if (ip_hlen < 20) return;
    t = 14 + ip_hlen;
    if (o < t) return;
    r = o - t;
    if (ip_proto_r == ehc_pkg::ProtoTcp || ip_proto_r == ehc_pkg::ProtoUdp) begin
      if (r < 2) sport_r = {sport_r[7:0], b};
      else if (r < 4) dport_r = {dport_r[7:0], b};
      if (ip_proto_r == ehc_pkg::ProtoTcp && r == 12) l4_hlen = {2'b00, b[7:4], 2'b00};
      if ((ip_proto_r == ehc_pkg::ProtoUdp || l4_hlen >= 20) && r >= l4_hlen &&
          pay_taken < expected_payload())
        take_payload_byte(b);
    end else if (ip_proto_r == ehc_pkg::ProtoIcmp) begin
      if (r == 0) icmp_tc = {b, 8'h00};
      else if (r == 1) icmp_tc[7:0] = b;
      else if (r == 4 || r == 5) icmp_id = {icmp_id[7:0], b};
      else if (r == 6 || r == 7) icmp_seq = {icmp_seq[7:0], b};
    end
  endfunction

  // Summary for a frame of len bytes, from the state captured so far.
  function automatic ehc_pkg::out_beat_t frame_summary(input int unsigned len);
    ehc_pkg::out_beat_t s;
    int unsigned t;
    logic [7:0]  ty;
    logic [7:0]  cd;
    logic [7:0]  ct;
    logic [15:0] psize;
    s = '0;
    s.frame_class = ehc_pkg::ClsTrunc;
    t = 14 + ip_hlen;
    if (eth_type == ehc_pkg::EtherArp) begin
      if (len < 42) return s;
      s.frame_class = ehc_pkg::ClsArp;
      s.source_address = src_ip;
      s.destination_address = dst_ip;
      return s;
    end
    if (len < 15) return s;
    if (ip_hlen < 20) begin
      s.frame_class = ehc_pkg::ClsBadIpHl;
      return s;
    end
    if (len < 34) return s;
    if (ip_proto_r == ehc_pkg::ProtoTcp) begin
      if (len < t + 13) return s;
      s.source_address = src_ip;
      s.destination_address = dst_ip;
      if (l4_hlen < 20) begin
        s.frame_class = ehc_pkg::ClsBadTcpHl;
        return s;
      end
      s.frame_class = ehc_pkg::ClsTcp;
    end else if (ip_proto_r == ehc_pkg::ProtoUdp) begin
      if (len < t + 4) return s;
      s.frame_class = ehc_pkg::ClsUdp;
      s.source_address = src_ip;
      s.destination_address = dst_ip;
    end else if (ip_proto_r == ehc_pkg::ProtoIcmp) begin
      ty = icmp_tc[15:8];
      cd = icmp_tc[7:0];
      if (len < t + 2 || (ty == 8 && len < t + 8)) return s;
      s.frame_class = ehc_pkg::ClsIcmp;
      s.source_address = src_ip;
      s.destination_address = dst_ip;
      if (ty == 0 && cd == 0) s.icmp_kind = ehc_pkg::IcmpEchoReply;
      else if (ty == 3 && cd == 1) s.icmp_kind = ehc_pkg::IcmpHostUnreach;
      else if (ty == 3 && cd == 3) s.icmp_kind = ehc_pkg::IcmpPortUnreach;
      else if (ty == 8 && cd == 0) s.icmp_kind = ehc_pkg::IcmpEchoReq;
      else s.icmp_kind = ehc_pkg::IcmpOther;
      s.icmp_type_code = icmp_tc;
      if (ty == 8) begin
        s.source_port = icmp_id;
        s.destination_port = icmp_seq;
      end
      return s;
    end else begin
      s.frame_class = (ip_proto_r == 0) ? ehc_pkg::ClsProtoNil : ehc_pkg::ClsUnknown;
      s.source_address = src_ip;
      s.destination_address = dst_ip;
      return s;
    end
    s.source_port = sport_r;
    s.destination_port = dport_r;
    psize = expected_payload();
    s.payload_size = psize;
    if (psize == 0) return s;
    if (ip_proto_r == ehc_pkg::ProtoTcp) begin
      if (sport_r == http_port_cfg || dport_r == http_port_cfg) begin
        s.app_kind = ehc_pkg::AppHttp;
        if (pay5_found[8]) begin
          s.app_code = 3'd1;
          s.app_value = http_len;
        end
      end else if (sport_r == tls_port_cfg || dport_r == tls_port_cfg) begin
        ct = pay01[15:8];
        s.app_kind = ehc_pkg::AppTls;
        if (ct == 8'h16) s.app_code = 3'd1;
        else if (ct == 8'h15) s.app_code = 3'd2;
        else if (ct == 8'h17) s.app_code = 3'd3;
        else if (ct == 8'h14) s.app_code = 3'd4;
        if (s.app_code == 3'd1) s.app_value = {8'h00, pay5_found[7:0]};
        if (s.app_code != 0 && pay01[7:0] == 8'h03 && pay23[15:8] >= 1 &&
            pay23[15:8] <= 3)
          s.tls_version = pay23[9:8];
      end
    end else if (sport_r == dns_port_cfg || dport_r == dns_port_cfg) begin
      s.app_kind = ehc_pkg::AppDns;
      s.app_value = pay01;
      if (pay23 == 16'h0100) s.app_code = 3'd1;
      else if (pay23 == 16'h8180) s.app_code = 3'd2;
      else if (pay23 == 16'h8103) s.app_code = 3'd3;
    end
    return s;
  endfunction

  // Advances the predictor by one accepted byte; returns 1 with a summary on
  // the last byte of a frame.
  function automatic bit classify_byte(input ehc_pkg::in_beat_t beat,
                                       output ehc_pkg::out_beat_t s);
    int unsigned o;
    o = cur_offset;
    capture_byte(o, beat.data_byte);
    if (!beat.end_of_frame) begin
      if (o < OffsetMax) cur_offset = o + 1;
      return 1'b0;
    end
    s = frame_summary(o + 1);
    clear_frame_state();
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_port(input int app);
    case (app)
      PlHttp: return http_port_cfg;
      PlTls: return tls_port_cfg;
      PlDns: return dns_port_cfg;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frame_spec_t spec(input int kind, input int eth, input int ihl,
                                       input int doff, input int app, input int ty,
                                       input int cd, input int cut, input int plen,
                                       input int pad);
    frame_spec_t f;
    f.kind = kind; f.eth = eth; f.ihl = ihl; f.doff = doff; f.app = app;
    f.icmp_ty = ty; f.icmp_cd = cd; f.cut = cut; f.plen = plen; f.pad = pad;
    return f;
  endfunction

  // Builds one frame from its spec and queues its bytes for the sender.
  task automatic queue_frame(input frame_spec_t f, input bit typed,
                             input ehc_pkg::out_beat_t fx);
    logic [7:0]  fr[$];
    logic [7:0]  hd[$];
    logic [7:0]  pl[$];
    int          ihl;
    int          doff;
    int          plen;
    int          app;
    int          ty;
    int          cd;
    int          tot;
    int          pad;
    int          n;
    int          k;
    logic [15:0] eth;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
    byte_item_t  it;
    repeat (12) fr.push_back(8'($urandom));
    if (f.kind == KArp) begin
      fr.push_back(8'h08);
      fr.push_back(8'h06);
      repeat (28) fr.push_back(8'($urandom));
    end else begin
      if (f.eth >= 0) eth = 16'(f.eth);
      else eth = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'h0800;
      if (eth == ehc_pkg::EtherArp) eth = 16'h86dd;
      fr.push_back(eth[15:8]);
      fr.push_back(eth[7:0]);
      if (f.ihl >= 0) ihl = f.ihl;
      else ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : 5;
      case (f.kind)
        KTcp: proto = ehc_pkg::ProtoTcp;
        KUdp: proto = ehc_pkg::ProtoUdp;
        KIcmp: proto = ehc_pkg::ProtoIcmp;
        KNil: proto = 8'd0;
        default: proto = 8'($urandom);
      endcase
      plen = (f.plen >= 0) ? f.plen :
             (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
      app = (f.app >= 0) ? f.app : $urandom_range(0, 3);
      for (k = 0; k < plen; k++) begin
        if (app == PlHttp) begin
          case ($urandom_range(0, 3))
            0: pl.push_back(ehc_pkg::ChrCr);
            1: pl.push_back(ehc_pkg::ChrLf);
            2: pl.push_back(8'h41);
            default: pl.push_back(8'($urandom));
          endcase
        end else begin
          pl.push_back(8'($urandom));
        end
      end
      if (app == PlHttp && plen >= 4 && $urandom_range(0, 3) != 0) begin
        n = $urandom_range(0, plen - 4);
        pl[n] = ehc_pkg::ChrCr; pl[n+1] = ehc_pkg::ChrLf;
        pl[n+2] = ehc_pkg::ChrCr; pl[n+3] = ehc_pkg::ChrLf;
      end
      if (app == PlTls && plen >= 3) begin
        case ($urandom_range(0, 4))
          0: pl[0] = 8'h16;
          1: pl[0] = 8'h15;
          2: pl[0] = 8'h17;
          3: pl[0] = 8'h14;
          default: pl[0] = 8'($urandom);
        endcase
        if ($urandom_range(0, 4) != 0) pl[1] = 8'h03;
        pl[2] = 8'($urandom_range(0, 4));
      end
      if (app == PlDns && plen >= 4) begin
        case ($urandom_range(0, 3))
          0: {pl[2], pl[3]} = 16'h0100;
          1: {pl[2], pl[3]} = 16'h8180;
          2: {pl[2], pl[3]} = 16'h8103;
          default: {pl[2], pl[3]} = 16'($urandom);
        endcase
      end
      sp = pick_port($urandom_range(0, 3));
      dp = pick_port(PlRand);
      if (app != PlRand) begin
        if ($urandom_range(0, 1)) sp = pick_port(app);
        else dp = pick_port(app);
      end
      if (f.kind == KTcp) begin
        doff = (f.doff >= 0) ? f.doff :
               (($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : 5);
        hd.push_back(sp[15:8]); hd.push_back(sp[7:0]);
        hd.push_back(dp[15:8]); hd.push_back(dp[7:0]);
        repeat (8) hd.push_back(8'($urandom));
        hd.push_back({4'(doff), 4'($urandom)});
        repeat (7) hd.push_back(8'($urandom));
        for (k = 5; k < doff; k++) repeat (4) hd.push_back(8'($urandom));
      end else if (f.kind == KUdp) begin
        hd.push_back(sp[15:8]); hd.push_back(sp[7:0]);
        hd.push_back(dp[15:8]); hd.push_back(dp[7:0]);
        repeat (4) hd.push_back(8'($urandom));
      end else if (f.kind == KIcmp) begin
        if (f.icmp_ty >= 0) begin
          ty = f.icmp_ty;
          cd = f.icmp_cd;
        end else begin
          case ($urandom_range(0, 6))
            0: begin ty = 0; cd = 0; end
            1: begin ty = 3; cd = 1; end
            2: begin ty = 3; cd = 3; end
            3: begin ty = 8; cd = 0; end
            4: begin ty = 8; cd = $urandom_range(0, 255); end
            5: begin ty = 3; cd = $urandom_range(0, 255); end
            default: begin ty = $urandom_range(0, 255); cd = $urandom_range(0, 255); end
          endcase
        end
        hd.push_back(8'(ty));
        hd.push_back(8'(cd));
        repeat (6) hd.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 8)) hd.push_back(8'($urandom));
      end
      tot = ihl * 4 + hd.size() + plen;
      if (f.plen < 0) begin
        case ($urandom_range(0, 7))
          0: tot = $urandom_range(0, 65535);
          1: tot = tot - $urandom_range(0, 30);
          2: tot = tot + $urandom_range(0, 30);
          default: ;
        endcase
      end
      if (tot < 0) tot = 0;
      if (tot > 65535) tot = 65535;
      fr.push_back({4'h4, 4'(ihl)});
      fr.push_back(8'($urandom));
      fr.push_back(8'(tot >> 8));
      fr.push_back(8'(tot));
      repeat (5) fr.push_back(8'($urandom));
      fr.push_back(proto);
      repeat (10) fr.push_back(8'($urandom));
      for (k = 5; k < ihl; k++) repeat (4) fr.push_back(8'($urandom));
      foreach (hd[j]) fr.push_back(hd[j]);
      foreach (pl[j]) fr.push_back(pl[j]);
    end
    pad = (f.pad >= 0) ? f.pad : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0);
    repeat (pad) fr.push_back(8'($urandom));
    if (f.cut > 0 && f.cut < fr.size()) fr = fr[0:f.cut-1];
    foreach (fr[j]) begin
      it.beat.data_byte = fr[j];
      it.beat.end_of_frame = (j == fr.size() - 1);
      it.typed = typed;
      it.fixed = fx;
      byte_q.push_back(it);
    end
  endtask

  // Sender: offers queued bytes, idling at random, and feeds the predictor
  // with every accepted beat.
  always @(posedge clk) begin
    ehc_pkg::out_beat_t s;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (classify_byte(offered.beat, s))
          summary_q.push_back(offered.typed ? offered.fixed : s);
      end
      if (!in_valid || in_ready) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = byte_q.pop_front();
          in_valid <= 1'b1;
          in_data <= offered.beat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each summary beat and applies random or long stalls.
  always @(posedge clk) begin
    ehc_pkg::out_beat_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (summary_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("summary beat with nothing expected: %h", out_data);
        end else begin
          want = summary_q.pop_front();
          if (out_data.frame_class !== want.frame_class ||
              out_data.source_address !== want.source_address ||
              out_data.destination_address !== want.destination_address ||
              out_data.source_port !== want.source_port ||
              out_data.destination_port !== want.destination_port ||
              out_data.payload_size !== want.payload_size ||
              out_data.app_kind !== want.app_kind ||
              out_data.app_code !== want.app_code ||
              out_data.app_value !== want.app_value ||
              out_data.tls_version !== want.tls_version ||
              out_data.icmp_kind !== want.icmp_kind ||
              out_data.icmp_type_code !== want.icmp_type_code) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: class %0d/%0d addr %h %h / %h %h ports %h %h / %h %h",
                       want.frame_class, out_data.frame_class, want.source_address,
                       want.destination_address, out_data.source_address,
                       out_data.destination_address, want.source_port,
                       want.destination_port, out_data.source_port,
                       out_data.destination_port);
              $display("  size %h/%h app %0d %0d %h / %0d %0d %h tls %0d/%0d icmp %0d %h / %0d %h",
                       want.payload_size, out_data.payload_size, want.app_kind,
                       want.app_code, want.app_value, out_data.app_kind,
                       out_data.app_code, out_data.app_value, want.tls_version,
                       out_data.tls_version, want.icmp_kind, want.icmp_type_code,
                       out_data.icmp_kind, out_data.icmp_type_code);
            end
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || summary_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_port(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ehc_pkg::RegHttpPort: http_port_cfg = value;
      ehc_pkg::RegTlsPort: tls_port_cfg = value;
      default: dns_port_cfg = value;
    endcase
  endtask

  task automatic write_ports(input logic [15:0] h, input logic [15:0] t,
                             input logic [15:0] d);
    wait_drained();
    write_port(ehc_pkg::RegHttpPort, h);
    write_port(ehc_pkg::RegTlsPort, t);
    write_port(ehc_pkg::RegDnsPort, d);
  endtask

  dir_row_t dir_rows[$];

  initial begin
    ehc_pkg::out_beat_t fx;
    frame_spec_t rs;
    logic [15:0] same;
    int          nfr;
    clear_frame_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames. Typed expectations cover the truncated frames and the
    // bad IP header length, whose other fields are all zero.
    dir_rows.push_back('{spec(KTcp, 16'h0800, 5, 5, PlRand, -1, -1, 1, 4, 0), 1,
                         ehc_pkg::ClsTrunc});
    dir_rows.push_back('{spec(KArp, -1, 5, 5, PlRand, -1, -1, 30, 0, 0), 1,
                         ehc_pkg::ClsTrunc});
    dir_rows.push_back('{spec(KArp, -1, 5, 5, PlRand, -1, -1, 0, 0, 0), 0,
                         ehc_pkg::ClsArp});
    dir_rows.push_back('{spec(KTcp, 16'h0800, 3, 5, PlRand, -1, -1, 0, 8, 0), 1,
                         ehc_pkg::ClsBadIpHl});
    dir_rows.push_back('{spec(KUdp, 16'h0800, 0, 5, PlRand, -1, -1, 0, 8, 0), 1,
                         ehc_pkg::ClsBadIpHl});
    dir_rows.push_back('{spec(KTcp, 16'h0800, 5, 2, PlRand, -1, -1, 0, 8, 0), 0,
                         ehc_pkg::ClsBadTcpHl});
    dir_rows.push_back('{spec(KTcp, 16'h0800, 5, 5, PlHttp, -1, -1, 0, 20, 0), 0,
                         ehc_pkg::ClsTcp});
    dir_rows.push_back('{spec(KTcp, 16'h0800, 5, 5, PlTls, -1, -1, 0, 12, 0), 0,
                         ehc_pkg::ClsTcp});
    dir_rows.push_back('{spec(KTcp, 16'h0800, 15, 15, PlTls, -1, -1, 0, 6, 0), 0,
                         ehc_pkg::ClsTcp});
    dir_rows.push_back('{spec(KUdp, 16'h0800, 5, 5, PlDns, -1, -1, 0, 12, 0), 0,
                         ehc_pkg::ClsUdp});
    dir_rows.push_back('{spec(KUdp, 16'h0800, 5, 5, PlDns, -1, -1, 0, 0, 0), 0,
                         ehc_pkg::ClsUdp});
    dir_rows.push_back('{spec(KIcmp, 16'h0800, 5, 5, PlRand, 0, 0, 0, 0, 0), 0,
                         ehc_pkg::ClsIcmp});
    dir_rows.push_back('{spec(KIcmp, 16'h0800, 5, 5, PlRand, 3, 1, 0, 0, 0), 0,
                         ehc_pkg::ClsIcmp});
    dir_rows.push_back('{spec(KIcmp, 16'h0800, 5, 5, PlRand, 3, 3, 0, 0, 0), 0,
                         ehc_pkg::ClsIcmp});
    dir_rows.push_back('{spec(KIcmp, 16'h0800, 5, 5, PlRand, 8, 0, 0, 4, 0), 0,
                         ehc_pkg::ClsIcmp});
    dir_rows.push_back('{spec(KIcmp, 16'h0800, 5, 5, PlRand, 8, 0, 39, 4, 0), 1,
                         ehc_pkg::ClsTrunc});
    dir_rows.push_back('{spec(KIcmp, 16'h0800, 5, 5, PlRand, 255, 255, 0, 0, 0), 0,
                         ehc_pkg::ClsIcmp});
    dir_rows.push_back('{spec(KNil, 16'h0800, 5, 5, PlRand, -1, -1, 0, 0, 0), 0,
                         ehc_pkg::ClsProtoNil});
    dir_rows.push_back('{spec(KOther, 16'hffff, 5, 5, PlRand, -1, -1, 0, 0, 0), 0,
                         ehc_pkg::ClsUnknown});

    send_idle_pct = 25;
    recv_idle_pct = 79;
    foreach (dir_rows[i]) begin
      fx = '0;
      fx.frame_class = dir_rows[i].cls;
      queue_frame(dir_rows[i].spec, dir_rows[i].typed, fx);
    end

    // Random frames across several port settings and three idling profiles.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: write_ports(16'd0, 16'd0, 16'd0);
        2: write_ports(16'hffff, 16'hffff, 16'hffff);
        3: write_ports(16'($urandom), 16'($urandom), 16'($urandom));
        4: begin
          same = 16'($urandom);
          write_ports(same, same, 16'($urandom));
        end
        5: write_ports(16'd80, 16'd443, 16'd53);
        6: write_ports(16'($urandom), 16'd443, 16'hffff);
        7: write_ports(16'd80, 16'd443, 16'd53);
        default: ;
      endcase
      if (ph < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 79;
      end else if (ph < 6) begin
        send_idle_pct = 79;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // A long receiver stall with the sender still streaming fills the
      // pipeline and backs pressure up onto the input.
      if (ph == 6) hold_req++;
      nfr = (ph == 6) ? 3 : ((ph == 4) ? 2 : 1);
      for (int fi = 0; fi < nfr; fi++) begin
        // Sender pauses once until every summary is back.
        if (ph == 4 && fi == 1) wait_drained();
        rs = spec($urandom_range(0, 5), -1, -1, -1, -1, -1, -1, 0, -1, -1);
        if ($urandom_range(0, 5) == 0) rs.cut = $urandom_range(1, 60);
        queue_frame(rs, 1'b0, '0);
      end
    end

    wait_drained();
    mismatches += summary_q.size();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
